FILE: hw/rtl/sha256_hash_engine_defines.svh
// assertion macros for the sha256 hash engine
// used by sha256_hash_engine.sv, no other dependencies
`ifndef SHA256_HASH_ENGINE_DEFINES_SVH
`define SHA256_HASH_ENGINE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SHA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("sha256 check failed");
`define SHA_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("sha256 check failed");
`else
`define SHA_ASSERT(lbl, clk, rst_n, prop)
`define SHA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: hw/rtl/sha_pkg.sv
// shared types, constants and functions of the sha256 hash engine
// no dependencies
`default_nettype none
package sha_pkg;
	typedef logic [31:0] word_t;
	typedef logic [7:0][31:0] hash_t;

	localparam hash_t INIT_HASH = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [5:0] LAST_POS = 6'h3F;
	localparam logic [5:0] LAST_ROUND = 6'd63;

	// round constants
	function automatic word_t round_k(input logic [5:0] i);
		word_t k;
		case (i)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			6'd63: k = 32'hc67178f2;
			default: k = '0;
		endcase
		return k;
	endfunction

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/sha_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module sha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: hw/rtl/sha_rnd.sv
// one sha256 round plus the message schedule word for that round
// depends on sha_pkg
`default_nettype none
module sha_rnd (
	input  wire sha_pkg::hash_t vars,
	input  wire sha_pkg::word_t w16,
	input  wire sha_pkg::word_t w15,
	input  wire sha_pkg::word_t w7,
	input  wire sha_pkg::word_t w2,
	input  wire sha_pkg::word_t ram_word,
	input  wire logic [5:0]     round,
	output sha_pkg::word_t      w_cur,
	output sha_pkg::hash_t      vars_next
);
	sha_pkg::word_t s0, s1, t1, t2, a, b, c, d, e, f, g, h;

	// schedule word: from the buffer for the first sixteen rounds
	always_comb begin
		s0 = sha_pkg::rotr(w15, 7) ^ sha_pkg::rotr(w15, 18) ^ (w15 >> 3);
		s1 = sha_pkg::rotr(w2, 17) ^ sha_pkg::rotr(w2, 19) ^ (w2 >> 10);
		w_cur = (round[5:4] == 2'b00) ? ram_word : (w16 + s0 + w7 + s1);
	end

	// compression round
	always_comb begin
		a = vars[0]; b = vars[1]; c = vars[2]; d = vars[3];
		e = vars[4]; f = vars[5]; g = vars[6]; h = vars[7];
		t1 = h + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
			+ ((e & f) ^ (~e & g)) + sha_pkg::round_k(round) + w_cur;
		t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
			+ ((a & b) ^ (a & c) ^ (b & c));
		vars_next = {g, f, e, d + t1, c, b, a, t1 + t2};
	end
endmodule
`default_nettype wire

FILE: hw/rtl/sha256_hash_engine.sv
// sha256 hash engine top level: byte intake, padding, compression sequencer
// depends on sha_pkg, sha_ram, sha_rnd and sha256_hash_engine_defines.svh
//
// A message byte is taken only in the idle state. Each full 64-byte block is then
// compressed: a buffer read ahead, 64 rounds at one round per cycle, a chaining
// add, during which no transaction is taken. An end-of-message transaction brings
// the pad and length bytes (9 to 72), one per cycle, then one or two compressions
// and eight output transactions, one per cycle when the consumer keeps ready high.
// The block buffer is a 16x32 ram; the round unit is the limit on throughput.
`default_nettype none
`include "sha256_hash_engine_defines.svh"
module sha256_hash_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        has_byte,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_message,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [31:0] digest_word,
	output logic      [2:0]  word_index,
	output logic             last_word
);
	typedef enum logic [2:0] {S_IDLE, S_PAD, S_LOAD, S_ROUND, S_FINAL, S_OUT} state_t;

	state_t          state_q;
	sha_pkg::hash_t  chain_q, vars_q, vars_next;
	logic [15:0][31:0] win_q;
	logic [5:0]      pos_q, round_q;
	logic [63:0]     bits_q, len_q;
	logic [23:0]     part_q;
	logic            pad_q, first_q, len_ph_q;
	logic [2:0]      idx_q;
	logic            dv_q;

	logic            put;
	logic [7:0]      put_byte;
	logic            we;
	logic [3:0]      raddr;
	sha_pkg::word_t  rdata, w_cur;
	logic            out_load;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = dv_q;
	assign out_load = (state_q == S_OUT) && (!dv_q || out_ready);

	// byte to place in the buffer this cycle
	always_comb begin
		put = 1'b0;
		put_byte = data_byte;
		if (state_q == S_IDLE) begin
			put = in_valid && has_byte;
		end else if (state_q == S_PAD) begin
			put = 1'b1;
			if (first_q) begin
				put_byte = sha_pkg::PAD_BYTE;
			end else if (len_ph_q || pos_q == sha_pkg::LEN_POS) begin
				put_byte = len_q[{~pos_q[2:0], 3'b000} +: 8];
			end else begin
				put_byte = 8'h00;
			end
		end
	end

	assign we = put && (pos_q[1:0] == 2'b11);
	assign raddr = (state_q == S_LOAD) ? 4'd0 : (round_q[3:0] + 4'd1);

	// block buffer
	sha_ram #(.WIDTH(32), .DEPTH(16)) u_buf (
		.clk   (clk),
		.we    (we),
		.waddr (pos_q[5:2]),
		.wdata ({part_q, put_byte}),
		.raddr (raddr),
		.rdata (rdata)
	);

	// round unit
	sha_rnd u_rnd (
		.vars      (vars_q),
		.w16       (win_q[0]),
		.w15       (win_q[1]),
		.w7        (win_q[9]),
		.w2        (win_q[14]),
		.ram_word  (rdata),
		.round     (round_q),
		.w_cur     (w_cur),
		.vars_next (vars_next)
	);

	// sequencer, buffer position and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			chain_q <= sha_pkg::INIT_HASH;
			pos_q <= '0;
			bits_q <= '0;
			round_q <= '0;
			pad_q <= 1'b0;
			first_q <= 1'b0;
			len_ph_q <= 1'b0;
			idx_q <= '0;
			dv_q <= 1'b0;
		end else begin
			// output word taken and no new word loaded behind it
			if (dv_q && out_ready && !out_load) begin
				dv_q <= 1'b0;
			end
			if (put) begin
				part_q <= {part_q[15:0], put_byte};
				pos_q <= pos_q + 6'd1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (has_byte) begin
							bits_q <= bits_q + 64'd8;
						end
						if (end_of_message) begin
							len_q <= has_byte ? bits_q + 64'd8 : bits_q;
							pad_q <= 1'b1;
							first_q <= 1'b1;
							len_ph_q <= 1'b0;
						end
						if (has_byte && pos_q == sha_pkg::LAST_POS) begin
							state_q <= S_LOAD;
						end else if (end_of_message) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					first_q <= 1'b0;
					if (!first_q && (len_ph_q || pos_q == sha_pkg::LEN_POS)) begin
						len_ph_q <= 1'b1;
					end
					if (pos_q == sha_pkg::LAST_POS) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					vars_q <= chain_q;
					round_q <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					vars_q <= vars_next;
					win_q <= {w_cur, win_q[15:1]};
					round_q <= round_q + 6'd1;
					if (round_q == sha_pkg::LAST_ROUND) begin
						state_q <= S_FINAL;
					end
				end
				S_FINAL: begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + vars_q[i];
					end
					if (len_ph_q) begin
						idx_q <= '0;
						state_q <= S_OUT;
					end else if (pad_q) begin
						state_q <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_load) begin
						dv_q <= 1'b1;
						digest_word <= chain_q[idx_q];
						word_index <= idx_q;
						last_word <= (idx_q == 3'd7);
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							chain_q <= sha_pkg::INIT_HASH;
							pos_q <= '0;
							bits_q <= '0;
							pad_q <= 1'b0;
							len_ph_q <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// the buffer is never written while a compression reads it
	`SHA_ASSERT(a_no_write_in_rounds, clk, arst_n, (state_q != S_IDLE && state_q != S_PAD) |-> !we)
	// the last digest word leaves the engine back at the start of a message
	`SHA_ASSERT(a_reinit, clk, arst_n, (out_load && idx_q == 3'd7) |=> (state_q == S_IDLE && bits_q == '0))
	// a compression only starts on a full block
	`SHA_ASSERT(a_load_on_full_block, clk, arst_n, (state_q == S_LOAD) |-> (pos_q == 6'd0))
	// output words only come out while the engine drains a digest or just after
	`SHA_ASSERT(a_out_from_drain, clk, arst_n, $rose(out_valid) |-> ($past(state_q) == S_OUT))
endmodule
`default_nettype wire

FILE: verif/sha256_digest_checker.sv
// digest checker for the sha256 hash engine: watches both channels, computes
// expected digests in-house and compares each output word; depends on sha_pkg
`default_nettype none
module sha256_digest_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic        has_byte,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_message,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [31:0] digest_word,
	input  wire logic [2:0]  word_index,
	input  wire logic        last_word,
	output int               fail_count,
	output int               pending_words,
	output int               digests_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_beat_t;

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	logic [31:0]  chain [8];
	logic [7:0]   blk [64];
	logic [5:0]   fill;
	logic [63:0]  bit_len;
	digest_beat_t digest_q [$];

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// one 64-round compression of the current block into the chain
	task automatic compress();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
				+ w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
		for (int i = 0; i < 8; i++)
			v[i] = chain[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] += v[i];
	endtask

	task automatic append_byte(input logic [7:0] b);
		blk[fill] = b;
		if (fill == sha_pkg::LAST_POS)
			compress();
		fill = fill + 6'd1;
	endtask

	task automatic restart_message();
		for (int i = 0; i < 8; i++)
			chain[i] = sha_pkg::INIT_HASH[i];
		fill = '0;
		bit_len = '0;
	endtask

	// pad, append length and queue the eight digest words
	task automatic finish_message();
		logic [63:0] len;
		len = bit_len;
		append_byte(sha_pkg::PAD_BYTE);
		while (fill != sha_pkg::LEN_POS)
			append_byte(8'h00);
		for (int i = 0; i < 8; i++)
			append_byte(len[63 - 8*i -: 8]);
		for (int i = 0; i < 8; i++)
			digest_q.push_back('{word: chain[i], idx: 3'(i), last: (i == 7)});
		restart_message();
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	// follow both channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		digest_beat_t exp_beat;
		if (!arst_n) begin
			restart_message();
			digest_q.delete();
			fail_count = 0;
			digests_seen = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (digest_q.size() == 0) begin
					report_mismatch("unexpected word", digest_word, 32'h0);
				end else begin
					exp_beat = digest_q.pop_front();
					if (digest_word !== exp_beat.word)
						report_mismatch("digest_word", digest_word, exp_beat.word);
					if (word_index !== exp_beat.idx)
						report_mismatch("word_index", 32'(word_index), 32'(exp_beat.idx));
					if (last_word !== exp_beat.last)
						report_mismatch("last_word", 32'(last_word), 32'(exp_beat.last));
					if (exp_beat.last)
						digests_seen++;
				end
			end
			if (in_valid && in_ready) begin
				if (has_byte) begin
					append_byte(data_byte);
					bit_len += 64'd8;
				end
				if (end_of_message)
					finish_message();
			end
		end
		pending_words = digest_q.size();
	end
endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// testbench top for the sha256 hash engine: clock, reset, byte stimulus
// and verdict; depends on sha256_hash_engine and sha256_digest_checker
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        has_byte = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	int          fail_count, pending_words, digests_seen;
	int          cycle_count = 0;
	int          bytes_sent = 0;
	int          burst_left = 0;

	sha256_hash_engine u_top (.*);
	sha256_digest_checker u_chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver stall pattern: long ready stretches, bursts of stalls
	always @(negedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else if ((cycle_count / 200) % 3 == 0)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(0, 3) != 0);
	end

	// one transaction; gaps between bursts of random length
	task automatic send(input logic hb, input logic [7:0] b, input logic eom);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 4);
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				has_byte <= 1'($urandom_range(0, 1));
				data_byte <= 8'($urandom_range(0, 255));
				end_of_message <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		has_byte <= hb;
		data_byte <= b;
		end_of_message <= eom;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++)
			send(1'b1, 8'($urandom_range(0, 255)), 1'b0);
		send(1'b0, 8'($urandom_range(0, 255)), 1'b1);
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed: empty message, idle steps, ignored byte, byte with end mark
		send(1'b0, 8'hff, 1'b1);
		send(1'b0, 8'h5a, 1'b0);
		send(1'b1, 8'h00, 1'b0);
		send(1'b0, 8'hff, 1'b0);
		send(1'b1, 8'hff, 1'b1);
		send(1'b1, 8'h61, 1'b0);
		send(1'b1, 8'h62, 1'b0);
		send(1'b1, 8'h63, 1'b1);
		// padding boundary: 56 bytes push the length into a second block
		send_message(56);
		// random short messages and idle steps
		while (bytes_sent < 100) begin
			if ($urandom_range(0, 3) == 0)
				send(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0);
			else begin
				for (int i = $urandom_range(0, 20); i > 0; i--)
					send(1'b1, 8'($urandom_range(0, 255)), 1'b0);
				send(1'b1, 8'($urandom_range(0, 255)), 1'b1);
			end
		end
		in_valid <= 1'b0;
		while (pending_words != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("sent %0d transactions, checked %0d digests (empty, boundary, multi-block)",
			bytes_sent, digests_seen);
		if (fail_count == 0 && pending_words == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire
